>>> src/i2cbm_pkg.sv
// i2cbm_pkg: shared types and constants of the bit-level i2c master
`default_nettype none

package i2cbm_pkg;

	localparam int DATA_BITS = 8;
	localparam int BIT_IDX_W = 4;
	localparam int DELAY_W   = 10;
	localparam int CFG_IDX_W = 1;

	localparam logic [2:0] OP_TICK     = 3'd0;
	localparam logic [2:0] OP_START    = 3'd1;
	localparam logic [2:0] OP_STOP     = 3'd2;
	localparam logic [2:0] OP_WRITE    = 3'd3;
	localparam logic [2:0] OP_READ     = 3'd4;
	localparam logic [2:0] OP_WAIT_ACK = 3'd5;

	localparam logic [CFG_IDX_W-1:0] CFG_ACK_TIMEOUT   = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_TICKS_PER_US  = 1'd1;

	localparam logic [7:0] ACK_TIMEOUT_RST = 8'd250;
	localparam logic [7:0] TICKS_PER_US_RST = 8'd1;

	localparam logic [1:0] DLY_1US = 2'd0;
	localparam logic [1:0] DLY_2US = 2'd1;
	localparam logic [1:0] DLY_4US = 2'd2;

	typedef enum logic [14:0] {
		PH_IDLE  = 15'b000000000000001,
		PH_ST1   = 15'b000000000000010,
		PH_ST2   = 15'b000000000000100,
		PH_SP1   = 15'b000000000001000,
		PH_SP2   = 15'b000000000010000,
		PH_WA1   = 15'b000000000100000,
		PH_WA2   = 15'b000000001000000,
		PH_WPOLL = 15'b000000010000000,
		PH_WRLO  = 15'b000000100000000,
		PH_WRHI  = 15'b000001000000000,
		PH_WRTL  = 15'b000010000000000,
		PH_RDLO  = 15'b000100000000000,
		PH_RDHI  = 15'b001000000000000,
		PH_RALO  = 15'b010000000000000,
		PH_RAHI  = 15'b100000000000000
	} phase_t;

	typedef struct packed {
		logic [2:0]           operation;
		logic [DATA_BITS-1:0] tx_byte;
		logic                 send_ack;
		logic                 sda_sample;
	} cmd_word_t;

	typedef struct packed {
		logic                 scl_level;
		logic                 sda_driven;
		logic                 sda_level;
		logic                 busy_res;
		logic                 done_res;
		logic [DATA_BITS-1:0] read_data;
		logic                 ack_failed;
	} res_word_t;

endpackage

`default_nettype wire

>>> src/i2c_bit_level_master.sv
// i2c_bit_level_master: bit-level i2c master sequencer, one word per timing tick
//
// cmd channel: one word per tick, carrying the sampled sda level and, while the
// sequencer is idle, a command (start, stop, write byte, read byte with ack or
// nack, wait for acknowledge). commands taken while busy are ignored.
// res channel: one word per cmd word, giving the pin levels after that tick,
// busy and done flags, the last read byte and the acknowledge failure flag.
// cfg channel: cfg_ready is always high; index 0 sets the acknowledge poll
// limit, index 1 the ticks per microsecond of bus delay. write only when idle.
// each taken word sits in the input register, and its result is then held in the result register.
// throughput: one word per clock while cmd_stall is low; the input register and the result register
// hold one word each, so a word is taken while a result waits to be taken.
// a stalled result holds; once both registers are full and the result is stalled, cmd_stall rises.
// reset: sequencer idle, scl high, sda driven high, poll limit 250,
// one tick per microsecond, read data and failure flag cleared.
`default_nettype none

module i2c_bit_level_master
	import i2cbm_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cmd_valid,
	output logic                      cmd_stall,
	input  wire cmd_word_t            cmd_word,
	output logic                      res_valid,
	input  wire logic                 res_stall,
	output res_word_t                 res_word,
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [7:0]           cfg_data
);

	logic                 valid_s1;
	cmd_word_t            cmd_s1;
	logic                 res_valid_q;
	res_word_t            res_q;
	logic                 advance;

	logic [7:0]           ack_timeout_q;
	logic [7:0]           ticks_per_us_q;

	phase_t               phase_q, phase_d;
	logic [2:0]           active_cmd_q, active_cmd_d;
	logic [DELAY_W-1:0]   delay_q, delay_d, delay_dec;
	logic [BIT_IDX_W-1:0] bit_q, bit_d, bit_inc;
	logic [DATA_BITS-1:0] shift_q, shift_d;
	logic [7:0]           poll_q, poll_d;
	logic                 ack_choice_q, ack_choice_d;
	logic                 scl_q, scl_d;
	logic                 drv_q, drv_d;
	logic                 lvl_q, lvl_d;
	logic [DATA_BITS-1:0] rd_byte_q, rd_byte_d;
	logic                 fail_q, fail_d;
	logic                 done_d;

	function automatic logic [DELAY_W-1:0] delay_ticks(input logic [1:0] units,
			input logic [7:0] tpu);
		logic [7:0] d;
		d = (tpu == 8'd0) ? 8'd1 : tpu;
		return {{(DELAY_W-8){1'b0}}, d} << units;
	endfunction

	assign advance   = valid_s1 && (!res_valid_q || !res_stall);
	assign cmd_stall = valid_s1 && res_valid_q && res_stall;
	assign cfg_ready = 1'b1;
	assign res_valid = res_valid_q;
	assign res_word  = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ack_timeout_q  <= ACK_TIMEOUT_RST;
			ticks_per_us_q <= TICKS_PER_US_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_ACK_TIMEOUT:  ack_timeout_q  <= cfg_data;
				CFG_TICKS_PER_US: ticks_per_us_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!cmd_stall) begin
			valid_s1 <= cmd_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!cmd_stall && cmd_valid) begin
			cmd_s1 <= cmd_word;
		end
	end

	assign delay_dec = (delay_q != '0) ? delay_q - 1'b1 : delay_q;
	assign bit_inc   = bit_q + 1'b1;

	always_comb begin
		phase_d      = phase_q;
		active_cmd_d = active_cmd_q;
		delay_d      = delay_q;
		bit_d        = bit_q;
		shift_d      = shift_q;
		poll_d       = poll_q;
		ack_choice_d = ack_choice_q;
		scl_d        = scl_q;
		drv_d        = drv_q;
		lvl_d        = lvl_q;
		rd_byte_d    = rd_byte_q;
		fail_d       = fail_q;
		done_d       = 1'b0;

		if (phase_q == PH_IDLE) begin
			if (cmd_s1.operation >= OP_START && cmd_s1.operation <= OP_WAIT_ACK) begin
				active_cmd_d = cmd_s1.operation;
			end
			case (cmd_s1.operation)
				OP_START: begin
					scl_d = 1'b1; drv_d = 1'b1; lvl_d = 1'b1;
					delay_d = delay_ticks(DLY_4US, ticks_per_us_q);
					phase_d = PH_ST1;
				end
				OP_STOP: begin
					scl_d = 1'b0; drv_d = 1'b1; lvl_d = 1'b0;
					delay_d = delay_ticks(DLY_4US, ticks_per_us_q);
					phase_d = PH_SP1;
				end
				OP_WRITE: begin
					bit_d   = '0;
					scl_d   = 1'b0; drv_d = 1'b1;
					lvl_d   = cmd_s1.tx_byte[DATA_BITS-1];
					shift_d = {cmd_s1.tx_byte[DATA_BITS-2:0], 1'b0};
					delay_d = delay_ticks(DLY_2US, ticks_per_us_q);
					phase_d = PH_WRLO;
				end
				OP_READ: begin
					shift_d      = '0;
					bit_d        = '0;
					ack_choice_d = cmd_s1.send_ack;
					scl_d = 1'b0; drv_d = 1'b0; lvl_d = 1'b1;
					delay_d = delay_ticks(DLY_2US, ticks_per_us_q);
					phase_d = PH_RDLO;
				end
				OP_WAIT_ACK: begin
					fail_d  = 1'b0;
					drv_d   = 1'b0; lvl_d = 1'b1;
					delay_d = delay_ticks(DLY_1US, ticks_per_us_q);
					phase_d = PH_WA1;
				end
				default: ;
			endcase
		end else if (phase_q == PH_WPOLL) begin
			if (!cmd_s1.sda_sample) begin
				scl_d   = 1'b0;
				phase_d = PH_IDLE;
				done_d  = 1'b1;
			end else if (poll_q >= ack_timeout_q) begin
				fail_d  = 1'b1;
				scl_d = 1'b0; drv_d = 1'b1; lvl_d = 1'b0;
				delay_d = delay_ticks(DLY_4US, ticks_per_us_q);
				phase_d = PH_SP1;
			end else begin
				poll_d = poll_q + 1'b1;
			end
		end else begin
			delay_d = delay_dec;
			if (delay_dec == '0) begin
				case (phase_q)
					PH_ST1: begin
						scl_d = 1'b1; drv_d = 1'b1; lvl_d = 1'b0;
						delay_d = delay_ticks(DLY_4US, ticks_per_us_q);
						phase_d = PH_ST2;
					end
					PH_ST2: begin
						scl_d = 1'b0; drv_d = 1'b1; lvl_d = 1'b0;
						phase_d = PH_IDLE;
						done_d  = 1'b1;
					end
					PH_SP1: begin
						scl_d = 1'b1; drv_d = 1'b1; lvl_d = 1'b1;
						delay_d = delay_ticks(DLY_4US, ticks_per_us_q);
						phase_d = PH_SP2;
					end
					PH_SP2: begin
						phase_d = PH_IDLE;
						done_d  = 1'b1;
					end
					PH_WA1: begin
						scl_d = 1'b1; drv_d = 1'b0; lvl_d = 1'b1;
						delay_d = delay_ticks(DLY_1US, ticks_per_us_q);
						phase_d = PH_WA2;
					end
					PH_WA2: begin
						poll_d  = '0;
						phase_d = PH_WPOLL;
					end
					PH_WRLO: begin
						scl_d   = 1'b1;
						delay_d = delay_ticks(DLY_2US, ticks_per_us_q);
						phase_d = PH_WRHI;
					end
					PH_WRHI: begin
						scl_d   = 1'b0;
						delay_d = delay_ticks(DLY_2US, ticks_per_us_q);
						phase_d = PH_WRTL;
					end
					PH_WRTL: begin
						bit_d = bit_inc;
						if (bit_inc >= BIT_IDX_W'(DATA_BITS)) begin
							phase_d = PH_IDLE;
							done_d  = 1'b1;
						end else begin
							scl_d   = 1'b0; drv_d = 1'b1;
							lvl_d   = shift_q[DATA_BITS-1];
							shift_d = {shift_q[DATA_BITS-2:0], 1'b0};
							delay_d = delay_ticks(DLY_2US, ticks_per_us_q);
							phase_d = PH_WRLO;
						end
					end
					PH_RDLO: begin
						scl_d = 1'b1; drv_d = 1'b0; lvl_d = 1'b1;
						shift_d = {shift_q[DATA_BITS-2:0], cmd_s1.sda_sample};
						delay_d = delay_ticks(DLY_1US, ticks_per_us_q);
						phase_d = PH_RDHI;
					end
					PH_RDHI: begin
						bit_d = bit_inc;
						if (bit_inc < BIT_IDX_W'(DATA_BITS)) begin
							scl_d = 1'b0; drv_d = 1'b0; lvl_d = 1'b1;
							delay_d = delay_ticks(DLY_2US, ticks_per_us_q);
							phase_d = PH_RDLO;
						end else begin
							rd_byte_d = shift_q;
							scl_d = 1'b0; drv_d = 1'b1; lvl_d = !ack_choice_q;
							delay_d = delay_ticks(DLY_2US, ticks_per_us_q);
							phase_d = PH_RALO;
						end
					end
					PH_RALO: begin
						scl_d   = 1'b1;
						delay_d = delay_ticks(DLY_2US, ticks_per_us_q);
						phase_d = PH_RAHI;
					end
					PH_RAHI: begin
						scl_d   = 1'b0;
						phase_d = PH_IDLE;
						done_d  = 1'b1;
					end
					default: phase_d = PH_IDLE;
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_IDLE;
			active_cmd_q <= OP_TICK;
			delay_q      <= '0;
			bit_q        <= '0;
			shift_q      <= '0;
			poll_q       <= '0;
			ack_choice_q <= 1'b0;
			scl_q        <= 1'b1;
			drv_q        <= 1'b1;
			lvl_q        <= 1'b1;
			rd_byte_q    <= '0;
			fail_q       <= 1'b0;
		end else if (advance) begin
			phase_q      <= phase_d;
			active_cmd_q <= active_cmd_d;
			delay_q      <= delay_d;
			bit_q        <= bit_d;
			shift_q      <= shift_d;
			poll_q       <= poll_d;
			ack_choice_q <= ack_choice_d;
			scl_q        <= scl_d;
			drv_q        <= drv_d;
			lvl_q        <= lvl_d;
			rd_byte_q    <= rd_byte_d;
			fail_q       <= fail_d;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q.scl_level  <= scl_d;
			res_q.sda_driven <= drv_d;
			res_q.sda_level  <= lvl_d;
			res_q.busy_res   <= (phase_d != PH_IDLE);
			res_q.done_res   <= done_d;
			res_q.read_data  <= rd_byte_d;
			res_q.ack_failed <= fail_d;
		end
	end

`ifndef SYNTHESIS
	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q |-> !(res_q.done_res && res_q.busy_res))
		else $error("done and busy together");

	a_released_high: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && !res_q.sda_driven |-> res_q.sda_level)
		else $error("released sda reported low");

	a_stall_needs_word: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_stall |-> valid_s1 && res_valid_q)
		else $error("stall without both registers full");

	a_tick_stays_idle: assert property (@(posedge clk) disable iff (!arst_n)
		advance && phase_q == PH_IDLE && cmd_s1.operation == OP_TICK
		|=> phase_q == PH_IDLE && res_valid_q && !res_q.busy_res)
		else $error("plain tick left idle");

	a_busy_tracks_phase: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> res_q.busy_res == (phase_q != PH_IDLE))
		else $error("busy flag out of step with sequencer");
`endif

endmodule

`default_nettype wire

>>> sim/tb_i2c_bit_level_master.sv
// tb_i2c_bit_level_master: self-checking testbench of the bit-level i2c master sequencer
module tb_i2c_bit_level_master
	import i2cbm_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [2:0] OP_UNUSED_6 = 3'd6;
	localparam logic [2:0] OP_UNUSED_7 = 3'd7;
	localparam int RANDOM_WORDS = 100;

	typedef enum {SDA_RANDOM, SDA_HIGH, SDA_LOW} sda_drive_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cmd_valid = 1'b0;
	logic                 cmd_stall;
	cmd_word_t            cmd_word = '0;
	logic                 res_valid;
	logic                 res_stall = 1'b0;
	res_word_t            res_word;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [7:0]           cfg_data = '0;

	i2c_bit_level_master dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd_word  (cmd_word),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_word  (res_word),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #5 clk = ~clk;

	// sequencer state as predicted, after the last accepted word
	phase_t               ph = PH_IDLE;
	logic [DELAY_W-1:0]   delay_left = '0;
	logic [BIT_IDX_W-1:0] bit_idx = '0;
	logic [DATA_BITS-1:0] shift_reg = '0;
	logic [7:0]           polls_done = '0;
	logic                 ack_sel = 1'b0;
	logic                 pin_scl = 1'b1;
	logic                 pin_drv = 1'b1;
	logic                 pin_lvl = 1'b1;
	logic [DATA_BITS-1:0] last_read = '0;
	logic                 ack_fail = 1'b0;
	logic [7:0]           poll_limit = ACK_TIMEOUT_RST;
	logic [7:0]           ticks_per_us = TICKS_PER_US_RST;

	res_word_t pending_bus_states[$];

	bit idling = 1'b1;
	int hold_cycles = 0;
	int mismatches = 0;
	int words_sent = 0;
	int results_checked = 0;
	int commands_started = 0;
	int ack_timeouts = 0;
	int cfg_writes = 0;

	function automatic void set_pins(input logic scl, input logic drv, input logic lvl);
		pin_scl = scl;
		pin_drv = drv;
		pin_lvl = drv ? lvl : 1'b1;
	endfunction

	function automatic logic [DELAY_W-1:0] delay_ticks(input int units);
		int unit_ticks;
		unit_ticks = (ticks_per_us == 8'd0) ? 1 : int'(ticks_per_us);
		return DELAY_W'(units * unit_ticks);
	endfunction

	function automatic void begin_stop();
		set_pins(1'b0, 1'b1, 1'b0);
		delay_left = delay_ticks(4);
		ph = PH_SP1;
	endfunction

	function automatic void put_bit();
		set_pins(1'b0, 1'b1, shift_reg[DATA_BITS-1]);
		shift_reg = shift_reg << 1;
		delay_left = delay_ticks(2);
		ph = PH_WRLO;
	endfunction

	function automatic res_word_t tick_sequencer(input cmd_word_t w);
		res_word_t r;
		logic fin;
		fin = 1'b0;
		if (ph == PH_IDLE) begin
			case (w.operation)
				OP_START: begin
					set_pins(1'b1, 1'b1, 1'b1);
					delay_left = delay_ticks(4);
					ph = PH_ST1;
				end
				OP_STOP: begin_stop();
				OP_WRITE: begin
					shift_reg = w.tx_byte;
					bit_idx = '0;
					put_bit();
				end
				OP_READ: begin
					shift_reg = '0;
					bit_idx = '0;
					ack_sel = w.send_ack;
					set_pins(1'b0, 1'b0, 1'b1);
					delay_left = delay_ticks(2);
					ph = PH_RDLO;
				end
				OP_WAIT_ACK: begin
					ack_fail = 1'b0;
					set_pins(pin_scl, 1'b0, 1'b1);
					delay_left = delay_ticks(1);
					ph = PH_WA1;
				end
				default: ;
			endcase
		end else if (ph == PH_WPOLL) begin
			if (!w.sda_sample) begin
				pin_scl = 1'b0;
				ph = PH_IDLE;
				fin = 1'b1;
			end else if (polls_done >= poll_limit) begin
				ack_fail = 1'b1;
				ack_timeouts++;
				begin_stop();
			end else begin
				polls_done++;
			end
		end else begin
			if (delay_left != '0) delay_left--;
			if (delay_left == '0) begin
				case (ph)
					PH_ST1: begin
						set_pins(1'b1, 1'b1, 1'b0);
						delay_left = delay_ticks(4);
						ph = PH_ST2;
					end
					PH_ST2: begin
						set_pins(1'b0, 1'b1, 1'b0);
						ph = PH_IDLE;
						fin = 1'b1;
					end
					PH_SP1: begin
						set_pins(1'b1, 1'b1, 1'b1);
						delay_left = delay_ticks(4);
						ph = PH_SP2;
					end
					PH_SP2: begin
						ph = PH_IDLE;
						fin = 1'b1;
					end
					PH_WA1: begin
						set_pins(1'b1, 1'b0, 1'b1);
						delay_left = delay_ticks(1);
						ph = PH_WA2;
					end
					PH_WA2: begin
						polls_done = '0;
						ph = PH_WPOLL;
					end
					PH_WRLO: begin
						pin_scl = 1'b1;
						delay_left = delay_ticks(2);
						ph = PH_WRHI;
					end
					PH_WRHI: begin
						pin_scl = 1'b0;
						delay_left = delay_ticks(2);
						ph = PH_WRTL;
					end
					PH_WRTL: begin
						bit_idx++;
						if (bit_idx >= DATA_BITS) begin
							ph = PH_IDLE;
							fin = 1'b1;
						end else begin
							put_bit();
						end
					end
					PH_RDLO: begin
						set_pins(1'b1, 1'b0, 1'b1);
						shift_reg = {shift_reg[DATA_BITS-2:0], w.sda_sample};
						delay_left = delay_ticks(1);
						ph = PH_RDHI;
					end
					PH_RDHI: begin
						bit_idx++;
						if (bit_idx < DATA_BITS) begin
							set_pins(1'b0, 1'b0, 1'b1);
							delay_left = delay_ticks(2);
							ph = PH_RDLO;
						end else begin
							last_read = shift_reg;
							set_pins(1'b0, 1'b1, !ack_sel);
							delay_left = delay_ticks(2);
							ph = PH_RALO;
						end
					end
					PH_RALO: begin
						pin_scl = 1'b1;
						delay_left = delay_ticks(2);
						ph = PH_RAHI;
					end
					PH_RAHI: begin
						pin_scl = 1'b0;
						ph = PH_IDLE;
						fin = 1'b1;
					end
					default: ph = PH_IDLE;
				endcase
			end
		end
		r.scl_level = pin_scl;
		r.sda_driven = pin_drv;
		r.sda_level = pin_lvl;
		r.busy_res = (ph != PH_IDLE);
		r.done_res = fin;
		r.read_data = last_read;
		r.ack_failed = ack_fail;
		return r;
	endfunction

	function automatic cmd_word_t make_word(input logic [2:0] op, input logic [7:0] tx,
			input logic ack, input logic sda);
		cmd_word_t w;
		w.operation = op;
		w.tx_byte = tx;
		w.send_ack = ack;
		w.sda_sample = sda;
		return w;
	endfunction

	function automatic logic sda_for(input sda_drive_t mode);
		if (mode == SDA_HIGH) return 1'b1;
		if (mode == SDA_LOW) return 1'b0;
		if (ph == PH_WPOLL) return $urandom_range(0, 3) != 0;
		return 1'($urandom);
	endfunction

	function automatic sda_drive_t pick_sda();
		case ($urandom_range(0, 9))
			0: return SDA_HIGH;
			1: return SDA_LOW;
			default: return SDA_RANDOM;
		endcase
	endfunction

	task automatic report_mismatch(input string msg);
		mismatches++;
		$display("[%0t] word %0d: %s", $time, results_checked, msg);
	endtask

	task automatic check_field(input string name, input logic [7:0] got, input logic [7:0] want);
		if (got !== want) report_mismatch($sformatf("%s is %0h, expected %0h", name, got, want));
	endtask

	task automatic send_word(input cmd_word_t w);
		int gap;
		gap = idling ? $urandom_range(0, 11) : 0;
		repeat (gap) begin
			@(negedge clk);
			cmd_valid <= 1'b0;
		end
		@(negedge clk);
		cmd_valid <= 1'b1;
		cmd_word <= w;
		do @(posedge clk); while (cmd_stall);
		if (ph == PH_IDLE && w.operation >= OP_START && w.operation <= OP_WAIT_ACK)
			commands_started++;
		pending_bus_states.push_back(tick_sequencer(w));
		words_sent++;
	endtask

	task automatic drain();
		@(negedge clk);
		cmd_valid <= 1'b0;
		while (pending_bus_states.size() != 0) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		if (idx == CFG_ACK_TIMEOUT) poll_limit = data;
		else ticks_per_us = data;
		cfg_writes++;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic set_config(input logic [7:0] polls, input logic [7:0] ticks);
		drain();
		write_reg(CFG_ACK_TIMEOUT, polls);
		write_reg(CFG_TICKS_PER_US, ticks);
	endtask

	// one command word, then ticks until the sequencer is idle again
	task automatic run_command(input logic [2:0] op, input logic [7:0] tx, input logic ack,
			input sda_drive_t mode);
		cmd_word_t w;
		send_word(make_word(op, tx, ack, sda_for(mode)));
		while (ph != PH_IDLE) begin
			w = make_word(OP_TICK, 8'($urandom), 1'($urandom), sda_for(mode));
			if ($urandom_range(0, 7) == 0) w.operation = 3'($urandom);
			send_word(w);
		end
	endtask

	task automatic idle_ticks(input int n);
		logic [2:0] op;
		repeat (n) begin
			case ($urandom_range(0, 3))
				0: op = OP_UNUSED_6;
				1: op = OP_UNUSED_7;
				default: op = OP_TICK;
			endcase
			send_word(make_word(op, 8'($urandom), 1'($urandom), 1'($urandom)));
		end
	endtask

	task automatic random_transaction();
		run_command(OP_START, 8'($urandom), 1'($urandom), pick_sda());
		run_command(OP_WRITE, 8'($urandom), 1'($urandom), pick_sda());
		run_command(OP_WAIT_ACK, 8'($urandom), 1'($urandom), pick_sda());
		repeat ($urandom_range(0, 3)) begin
			if ($urandom_range(0, 1)) begin
				run_command(OP_WRITE, 8'($urandom), 1'($urandom), pick_sda());
				run_command(OP_WAIT_ACK, 8'($urandom), 1'($urandom), pick_sda());
			end else begin
				run_command(OP_READ, 8'($urandom), 1'($urandom), pick_sda());
			end
		end
		run_command(OP_STOP, 8'($urandom), 1'($urandom), pick_sda());
	endtask

	task automatic test_reset_state();
		send_word(make_word(OP_TICK, 8'h00, 1'b0, 1'b0));
		send_word(make_word(OP_UNUSED_6, 8'hFF, 1'b1, 1'b1));
		send_word(make_word(OP_UNUSED_7, 8'hA5, 1'b0, 1'b1));
	endtask

	task automatic test_each_command();
		run_command(OP_START, 8'h00, 1'b0, SDA_RANDOM);
		run_command(OP_WRITE, 8'h00, 1'b0, SDA_RANDOM);
		run_command(OP_WAIT_ACK, 8'h00, 1'b0, SDA_LOW);
		run_command(OP_WRITE, 8'hFF, 1'b1, SDA_RANDOM);
		run_command(OP_WAIT_ACK, 8'hFF, 1'b1, SDA_RANDOM);
		run_command(OP_READ, 8'h00, 1'b1, SDA_HIGH);
		run_command(OP_READ, 8'hFF, 1'b0, SDA_LOW);
		run_command(OP_READ, 8'h5A, 1'b1, SDA_RANDOM);
		run_command(OP_STOP, 8'h00, 1'b0, SDA_RANDOM);
	endtask

	task automatic test_ack_timeout();
		// zero limit fails on the first high sample
		set_config(8'd0, TICKS_PER_US_RST);
		run_command(OP_WAIT_ACK, 8'h00, 1'b0, SDA_HIGH);
		run_command(OP_WAIT_ACK, 8'h00, 1'b0, SDA_LOW);
		set_config(8'd255, TICKS_PER_US_RST);
		run_command(OP_WAIT_ACK, 8'hFF, 1'b1, SDA_HIGH);
		run_command(OP_WAIT_ACK, 8'hFF, 1'b1, SDA_RANDOM);
	endtask

	task automatic test_delay_extremes();
		// zero unit behaves as one tick
		set_config(ACK_TIMEOUT_RST, 8'd0);
		run_command(OP_START, 8'h00, 1'b0, SDA_RANDOM);
		run_command(OP_WRITE, 8'($urandom), 1'b0, SDA_RANDOM);
		// four-unit delay reaching above the low eight bits of the count
		set_config(ACK_TIMEOUT_RST, 8'd64);
		idling = 1'b0;
		run_command(OP_STOP, 8'h00, 1'b0, SDA_RANDOM);
		idling = 1'b1;
		set_config(ACK_TIMEOUT_RST, TICKS_PER_US_RST);
	endtask

	task automatic test_backpressure();
		idling = 1'b0;
		hold_cycles = 60;
		run_command(OP_WRITE, 8'($urandom), 1'b0, SDA_RANDOM);
		run_command(OP_READ, 8'($urandom), 1'($urandom), SDA_RANDOM);
		idling = 1'b1;
		drain();
		run_command(OP_START, 8'($urandom), 1'b0, SDA_RANDOM);
	endtask

	task automatic test_random_traffic();
		int first_word;
		logic [7:0] polls;
		logic [7:0] ticks;
		first_word = words_sent;
		while (words_sent - first_word < RANDOM_WORDS) begin
			case ($urandom_range(0, 7))
				0: polls = 8'd0;
				1: polls = ACK_TIMEOUT_RST;
				default: polls = 8'($urandom_range(1, 12));
			endcase
			case ($urandom_range(0, 5))
				0: ticks = 8'd0;
				1: ticks = 8'd2;
				2: ticks = 8'd3;
				default: ticks = 8'd1;
			endcase
			set_config(polls, ticks);
			idling = ($urandom_range(0, 3) != 0);
			repeat ($urandom_range(2, 5)) begin
				if (words_sent - first_word < RANDOM_WORDS) begin
					case ($urandom_range(0, 9))
						0: idle_ticks($urandom_range(1, 6));
						1: run_command(3'($urandom_range(1, 5)), 8'($urandom),
							1'($urandom), pick_sda());
						default: random_transaction();
					endcase
				end
			end
		end
		idling = 1'b1;
	endtask

	// result side: own stalls, one long hold-off on request
	initial begin
		int n;
		forever begin
			if (hold_cycles > 0) begin
				n = hold_cycles;
				hold_cycles = 0;
			end else begin
				n = idling ? $urandom_range(0, 11) : 0;
			end
			repeat (n) begin
				@(negedge clk);
				res_stall <= 1'b1;
			end
			@(negedge clk);
			res_stall <= 1'b0;
			do @(posedge clk); while (!res_valid);
			if (pending_bus_states.size() == 0) begin
				report_mismatch("result word with nothing expected");
			end else begin
				res_word_t want;
				want = pending_bus_states.pop_front();
				check_field("scl_level", 8'(res_word.scl_level), 8'(want.scl_level));
				check_field("sda_driven", 8'(res_word.sda_driven), 8'(want.sda_driven));
				check_field("sda_level", 8'(res_word.sda_level), 8'(want.sda_level));
				check_field("busy_res", 8'(res_word.busy_res), 8'(want.busy_res));
				check_field("done_res", 8'(res_word.done_res), 8'(want.done_res));
				check_field("read_data", res_word.read_data, want.read_data);
				check_field("ack_failed", 8'(res_word.ack_failed), 8'(want.ack_failed));
			end
			results_checked++;
		end
	end

	initial begin
		#10ms;
		$display("timeout with %0d results outstanding", pending_bus_states.size());
		$display("FAILED: results differ");
		$finish;
	end

	initial begin
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_reset_state();
		test_each_command();
		test_ack_timeout();
		test_delay_extremes();
		test_backpressure();
		test_random_traffic();
		drain();
		repeat (3) @(posedge clk);
		if (pending_bus_states.size() != 0) report_mismatch("results missing at end");
		$display("covered %0d words, %0d commands, %0d ack timeouts, %0d register writes",
			words_sent, commands_started, ack_timeouts, cfg_writes);
		$display("checked %0d result words, %0d mismatches", results_checked, mismatches);
		if (mismatches == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule
